>>> src/cspd_pkg.sv
package cspd_pkg;

    localparam int IN_W      = 32;
    localparam int COEF_W    = 32;
    localparam int N_COEF    = 10;
    localparam int N_CFG     = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int WIDE_W    = 128;
    localparam int ROOT_W    = 64;
    localparam int OUT_W     = 48;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic FUNC_HEIGHT = 1'b0;
    localparam logic FUNC_DIST   = 1'b1;

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic                     func;
        logic signed [IN_W-1:0]   x_coord;
        logic signed [IN_W-1:0]   y_coord;
        logic signed [IN_W-1:0]   z_coord;
    } point_t;

    // per-request data that rides along the root and divide pipelines
    typedef struct packed {
        logic                     is_dist;
        logic                     sat;
        logic [OUT_W-1:0]         hres;
        logic [WIDE_W-1:0]        num;
    } carry_t;

endpackage

>>> src/cspd_if.sv
interface cspd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  func;
    logic signed [cspd_pkg::IN_W-1:0]      x_coord;
    logic signed [cspd_pkg::IN_W-1:0]      y_coord;
    logic signed [cspd_pkg::IN_W-1:0]      z_coord;

    modport source (output valid, func, x_coord, y_coord, z_coord, input ready);
    modport sink (input valid, func, x_coord, y_coord, z_coord, output ready);
endinterface

interface cspd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cspd_pkg::OUT_W-1:0]     result_value;
    logic                                  saturated;

    modport source (output valid, result_value, saturated, input ready);
    modport sink (input valid, result_value, saturated, output ready);
endinterface

>>> src/cubic_surface_point_distance_top.sv
// pipeline from request accept to result valid:
// 10 polynomial stages, 64 root stages, 50 divide stages
// throughput: one request per cycle while results are taken; a stage holds one
// request, moving when a later slot is free, so input is taken while a result waits
// reset: asynchronous active low, clears all valid bits and zeroes the coefficients
module cubic_surface_point_distance_top #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cspd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cspd_pkg::CFG_W-1:0]          cfg_data,
    cspd_in_if.sink                             point,
    cspd_out_if.source                          result
);

    logic [cspd_pkg::CFG_W-1:0]     cfg_reg [cspd_pkg::N_CFG];
    cspd_pkg::coef_t                coef [cspd_pkg::N_COEF];
    cspd_pkg::point_t               pt;

    logic                           p_valid;
    logic                           p_ready;
    cspd_pkg::carry_t               p_data;
    logic [cspd_pkg::WIDE_W-1:0]    p_g;
    logic                           r_valid;
    logic                           r_ready;
    cspd_pkg::carry_t               r_data;
    logic [cspd_pkg::ROOT_W-1:0]    r_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cspd_pkg::N_CFG; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < cspd_pkg::CFG_IDX_W'(cspd_pkg::N_CFG)))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    for (genvar i = 0; i < cspd_pkg::N_CFG; i++) begin : g_coef
        assign coef[2*i]   = cfg_reg[i][cspd_pkg::COEF_W-1:0];
        assign coef[2*i+1] = cfg_reg[i][cspd_pkg::CFG_W-1:cspd_pkg::COEF_W];
    end

    assign pt.func    = point.func;
    assign pt.x_coord = point.x_coord;
    assign pt.y_coord = point.y_coord;
    assign pt.z_coord = point.z_coord;

    cspd_poly #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .in_data   (pt),
        .coef      (coef),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_data  (p_data),
        .out_g     (p_g)
    );

    cspd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_g      (p_g),
        .in_data   (p_data),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_s     (r_s),
        .out_data  (r_data)
    );

    cspd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_s      (r_s),
        .in_data   (r_data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_value (result.result_value),
        .out_sat   (result.saturated)
    );

endmodule

>>> src/cspd_mul.sv
module cspd_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                    clk,
    input  logic [1:0]              en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int CH  = 32;
    localparam int NA  = (AW + CH - 1) / CH;
    localparam int NB  = (BW + CH - 1) / CH;
    localparam int AXW = NA * CH;
    localparam int BXW = NB * CH;
    localparam int PW  = AXW + BXW;

    logic signed [AXW-1:0]  ax;
    logic signed [BXW-1:0]  bx;
    logic signed [2*CH+1:0] pp_reg [NA][NB];
    logic signed [PW-1:0]   acc;
    logic signed [AW+BW-1:0] p_reg;

    assign ax = AXW'(a);
    assign bx = BXW'(b);

    // lower chunks are unsigned, the top chunk carries the sign
    for (genvar i = 0; i < NA; i++) begin : g_a
        for (genvar j = 0; j < NB; j++) begin : g_b
            logic signed [CH:0] ac;
            logic signed [CH:0] bc;
            if (i == NA - 1) begin : g_as
                assign ac = $signed({ax[i*CH+CH-1], ax[i*CH +: CH]});
            end else begin : g_au
                assign ac = $signed({1'b0, ax[i*CH +: CH]});
            end
            if (j == NB - 1) begin : g_bs
                assign bc = $signed({bx[j*CH+CH-1], bx[j*CH +: CH]});
            end else begin : g_bu
                assign bc = $signed({1'b0, bx[j*CH +: CH]});
            end
            always_ff @(posedge clk)
            begin
                if (en[0])
                begin
                    pp_reg[i][j] <= ac * bc;
                end
            end
        end
    end

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (PW'(pp_reg[i][j]) <<< (CH * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p_reg <= acc[AW+BW-1:0];
        end
    end

    assign p = p_reg;

endmodule

>>> src/cspd_poly.sv
module cspd_poly #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cspd_pkg::point_t                in_data,
    input  cspd_pkg::coef_t                 coef [cspd_pkg::N_COEF],
    output logic                            out_valid,
    input  logic                            out_ready,
    output cspd_pkg::carry_t                out_data,
    output logic [cspd_pkg::WIDE_W-1:0]     out_g
);

    localparam int F    = FRAC_BITS;
    localparam int CW   = COORD_WIDTH;
    localparam int CFW  = cspd_pkg::COEF_W;
    localparam int WW   = cspd_pkg::WIDE_W;
    localparam int RTW  = cspd_pkg::ROOT_W;
    localparam int OW   = cspd_pkg::OUT_W;
    localparam int NST  = 10;
    localparam int L1_COEF [6] = '{1, 2, 3, 4, 4, 5};
    localparam int L2_COEF [9] = '{3, 4, 5, 6, 7, 8, 7, 8, 9};

    logic [NST:1]              v_reg;
    logic [NST:1]              en;
    logic [NST:1]              v_in;

    logic signed [CW-1:0]      x_reg [1:3];
    logic signed [CW-1:0]      y_reg [1:3];
    logic signed [CW-1:0]      z_reg [1:8];
    logic                      func_reg [1:9];

    logic signed [2*CW-1:0]    mono2 [3];
    logic signed [3*CW-1:0]    mono3 [4];
    logic signed [CFW+CW-1:0]  p1 [6];
    logic signed [CFW+CW-1:0]  p1d_reg [4:5][6];
    logic signed [CFW+2*CW-1:0] p2 [9];
    logic signed [CFW+3*CW-1:0] p3 [4];
    logic signed [2*RTW-1:0]   sq [2];

    logic signed [WW-1:0]      flow_reg [6:7];
    logic signed [WW-1:0]      grad_reg [2];
    logic [RTW-2:0]            mag_reg [2];
    logic [RTW-2:0]            mag_next [2];
    logic [1:0]                gclip;
    logic                      gsat_reg [7:9];
    logic signed [WW-1:0]      f8_reg;
    logic signed [WW-1:0]      d9_reg;
    logic signed [WW-1:0]      hs;
    logic                      h_ok;
    logic [OW-1:0]             hres9_reg;
    logic                      hsat9_reg;
    logic [WW-1:0]             g_reg;
    cspd_pkg::carry_t          cr_reg;

    // valid bits; a stage moves when it or any later stage has a hole or the sink takes
    assign v_in = {v_reg[NST-1:1], in_valid};
    for (genvar k = 1; k <= NST; k++) begin : g_en
        assign en[k] = out_ready || !(&v_reg[NST:k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (v_in & en) | (v_reg & ~en);
        end
    end

    assign in_ready  = en[1];
    assign out_valid = v_reg[NST];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            x_reg[1]    <= in_data.x_coord[CW-1:0];
            y_reg[1]    <= in_data.y_coord[CW-1:0];
            z_reg[1]    <= in_data.z_coord[CW-1:0];
            func_reg[1] <= in_data.func;
        end
        for (int k = 2; k <= 3; k++)
        begin
            if (en[k])
            begin
                x_reg[k] <= x_reg[k-1];
                y_reg[k] <= y_reg[k-1];
            end
        end
        for (int k = 2; k <= 8; k++)
        begin
            if (en[k])
            begin
                z_reg[k] <= z_reg[k-1];
            end
        end
        for (int k = 2; k <= 9; k++)
        begin
            if (en[k])
            begin
                func_reg[k] <= func_reg[k-1];
            end
        end
    end

    // x^2, xy, y^2
    for (genvar g = 0; g < 3; g++) begin : g_mono2
        logic signed [CW-1:0] ma;
        logic signed [CW-1:0] mb;
        assign ma = (g == 2) ? y_reg[1] : x_reg[1];
        assign mb = (g == 0) ? x_reg[1] : y_reg[1];
        cspd_mul #(.AW(CW), .BW(CW)) u_mul (
            .clk (clk),
            .en  ({en[3], en[2]}),
            .a   (ma),
            .b   (mb),
            .p   (mono2[g])
        );
    end

    // linear coefficient products: c1x c2y c3x c4y c4x c5y
    for (genvar g = 0; g < 6; g++) begin : g_p1
        logic signed [CW-1:0] mb;
        assign mb = (g % 2 == 0) ? x_reg[1] : y_reg[1];
        cspd_mul #(.AW(CFW), .BW(CW)) u_mul (
            .clk (clk),
            .en  ({en[3], en[2]}),
            .a   (coef[L1_COEF[g]]),
            .b   (mb),
            .p   (p1[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            p1d_reg[4] <= p1;
        end
        if (en[5])
        begin
            p1d_reg[5] <= p1d_reg[4];
        end
    end

    // x^3, x^2 y, x y^2, y^3
    for (genvar g = 0; g < 4; g++) begin : g_mono3
        logic signed [2*CW-1:0] ma;
        logic signed [CW-1:0]   mb;
        assign ma = (g < 2) ? mono2[0] : mono2[2];
        assign mb = (g % 2 == 0) ? x_reg[3] : y_reg[3];
        cspd_mul #(.AW(2*CW), .BW(CW)) u_mul (
            .clk (clk),
            .en  ({en[5], en[4]}),
            .a   (ma),
            .b   (mb),
            .p   (mono3[g])
        );
    end

    // quadratic coefficient products: c3xx c4xy c5yy c6xx c7xy c8yy c7xx c8xy c9yy
    for (genvar g = 0; g < 9; g++) begin : g_p2
        cspd_mul #(.AW(2*CW), .BW(CFW)) u_mul (
            .clk (clk),
            .en  ({en[5], en[4]}),
            .a   (mono2[g % 3]),
            .b   (coef[L2_COEF[g]]),
            .p   (p2[g])
        );
    end

    // cubic terms c6..c9 times their monomials
    for (genvar g = 0; g < 4; g++) begin : g_p3
        cspd_mul #(.AW(3*CW), .BW(CFW)) u_mul (
            .clk (clk),
            .en  ({en[7], en[6]}),
            .a   (mono3[g]),
            .b   (coef[6+g]),
            .p   (p3[g])
        );
    end

    // stage 6: low-degree part of f at scale 4F, partials at scale 3F
    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            flow_reg[6] <= (WW'(coef[0]) <<< (3 * F))
                + ((WW'(p1d_reg[5][0]) + WW'(p1d_reg[5][1])) <<< (2 * F))
                + ((WW'(p2[0]) + WW'(p2[1]) + WW'(p2[2])) <<< F);
            grad_reg[0] <= (WW'(coef[1]) <<< (2 * F))
                + (((WW'(p1d_reg[5][2]) <<< 1) + WW'(p1d_reg[5][3])) <<< F)
                + WW'(p2[3]) + (WW'(p2[3]) <<< 1)
                + (WW'(p2[4]) <<< 1) + WW'(p2[5]);
            grad_reg[1] <= (WW'(coef[2]) <<< (2 * F))
                + ((WW'(p1d_reg[5][4]) + (WW'(p1d_reg[5][5]) <<< 1)) <<< F)
                + WW'(p2[6]) + (WW'(p2[7]) <<< 1)
                + WW'(p2[8]) + (WW'(p2[8]) <<< 1);
        end
    end

    // stage 7: partials floored to scale F, magnitude clipped to 63 bits
    for (genvar k = 0; k < 2; k++) begin : g_mag
        logic signed [WW-1:0] sh;
        logic [WW-1:0]        ab;
        assign sh = grad_reg[k] >>> (2 * F);
        assign ab = sh[WW-1] ? -sh : sh;
        assign gclip[k]    = |ab[WW-1:RTW-1];
        assign mag_next[k] = gclip[k] ? '1 : ab[RTW-2:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            flow_reg[7] <= flow_reg[6];
            mag_reg     <= mag_next;
            gsat_reg[7] <= |gclip;
        end
        if (en[8])
        begin
            f8_reg      <= flow_reg[7] + WW'(p3[0]) + WW'(p3[1]) + WW'(p3[2]) + WW'(p3[3]);
            gsat_reg[8] <= gsat_reg[7];
        end
    end

    for (genvar k = 0; k < 2; k++) begin : g_sq
        logic signed [RTW-1:0] mw;
        assign mw = $signed({1'b0, mag_reg[k]});
        cspd_mul #(.AW(RTW), .BW(RTW)) u_mul (
            .clk (clk),
            .en  ({en[9], en[8]}),
            .a   (mw),
            .b   (mw),
            .p   (sq[k])
        );
    end

    // stage 9: height clip and the signed gap to z
    assign hs   = f8_reg >>> (3 * F);
    assign h_ok = (&hs[WW-1:OW-1]) || !(|hs[WW-1:OW-1]);

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            d9_reg      <= (WW'(z_reg[8]) <<< (3 * F)) - f8_reg;
            hres9_reg   <= h_ok ? hs[OW-1:0] : (hs[WW-1] ? cspd_pkg::OUT_MIN : cspd_pkg::OUT_MAX);
            hsat9_reg   <= !h_ok;
            gsat_reg[9] <= gsat_reg[8];
        end
        if (en[10])
        begin
            g_reg          <= (WW'(1) << (2 * F)) + WW'(sq[0]) + WW'(sq[1]);
            cr_reg.num     <= d9_reg[WW-1] ? -d9_reg : d9_reg;
            cr_reg.is_dist <= (func_reg[9] == cspd_pkg::FUNC_DIST);
            cr_reg.sat     <= (func_reg[9] == cspd_pkg::FUNC_DIST) ? gsat_reg[9] : hsat9_reg;
            cr_reg.hres    <= hres9_reg;
        end
    end

    assign out_data = cr_reg;
    assign out_g    = g_reg;

endmodule

>>> src/cspd_sqrt.sv
module cspd_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cspd_pkg::WIDE_W-1:0]     in_g,
    input  cspd_pkg::carry_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cspd_pkg::ROOT_W-1:0]     out_s,
    output cspd_pkg::carry_t                out_data
);

    localparam int WW  = cspd_pkg::WIDE_W;
    localparam int NST = cspd_pkg::ROOT_W;

    logic [NST-1:0]        v_reg;
    logic [NST-1:0]        en;
    logic [NST-1:0]        v_in;
    logic [WW-1:0]         rem_reg [NST];
    logic [WW-1:0]         res_reg [NST];
    cspd_pkg::carry_t      cr_reg [NST];

    assign v_in = {v_reg[NST-2:0], in_valid};
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = out_ready || !(&v_reg[NST-1:k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (v_in & en) | (v_reg & ~en);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];

    // one root bit per stage, from the top down
    for (genvar k = 0; k < NST; k++) begin : g_step
        localparam logic [WW-1:0] BIT_K = WW'(1) << (WW - 2 - 2 * k);
        logic [WW-1:0]    rem_in;
        logic [WW-1:0]    res_in;
        logic [WW-1:0]    trial;
        cspd_pkg::carry_t cr_in;
        logic             ge;
        if (k == 0) begin : g_first
            assign rem_in = in_g;
            assign res_in = '0;
            assign cr_in  = in_data;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
            assign cr_in  = cr_reg[k-1];
        end
        assign trial = res_in + BIT_K;
        assign ge    = rem_in >= trial;
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k] <= ge ? rem_in - trial : rem_in;
                res_reg[k] <= ge ? (res_in >> 1) + BIT_K : res_in >> 1;
                cr_reg[k]  <= cr_in;
            end
        end
    end

    assign out_s    = res_reg[NST-1][cspd_pkg::ROOT_W-1:0];
    assign out_data = cr_reg[NST-1];

endmodule

>>> src/cspd_div.sv
module cspd_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cspd_pkg::ROOT_W-1:0]         in_s,
    input  cspd_pkg::carry_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cspd_pkg::OUT_W-1:0]   out_value,
    output logic                                out_sat
);

    localparam int F   = FRAC_BITS;
    localparam int WW  = cspd_pkg::WIDE_W;
    localparam int RW  = cspd_pkg::ROOT_W;
    localparam int QW  = cspd_pkg::OUT_W;
    localparam int NST = QW + 2;

    logic [NST-1:0]        v_reg;
    logic [NST-1:0]        en;
    logic [NST-1:0]        v_in;
    logic [RW-1:0]         rem_reg [QW+1];
    logic [RW-1:0]         s_reg [QW+1];
    logic [QW-1:0]         q_reg [QW+1];
    logic [QW-1:0]         low_reg [QW+1];
    logic                  qs_reg [QW+1];
    cspd_pkg::carry_t      cr_reg [QW+1];
    logic [WW-1:0]         np;
    logic [WW-1:0]         top;
    logic                  q_over;
    logic [QW-1:0]         res_reg;
    logic                  sat_reg;

    assign v_in = {v_reg[NST-2:0], in_valid};
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = out_ready || !(&v_reg[NST-1:k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (v_in & en) | (v_reg & ~en);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];

    // quotient of num / 2^2F by s; anything at or above 2^48 saturates up front
    assign np  = in_data.num >> (2 * F);
    assign top = np >> QW;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            qs_reg[0]  <= top >= WW'(in_s);
            rem_reg[0] <= top[RW-1:0];
            low_reg[0] <= np[QW-1:0];
            q_reg[0]   <= '0;
            s_reg[0]   <= in_s;
            cr_reg[0]  <= in_data;
        end
    end

    // restoring steps, remainder stays below s unless the quotient saturated up front
    for (genvar j = 1; j <= QW; j++) begin : g_step
        logic [RW:0] trial;
        logic [RW:0] diff;
        logic        ge;
        assign trial = {rem_reg[j-1], low_reg[j-1][QW-j]};
        assign diff  = trial - {1'b0, s_reg[j-1]};
        assign ge    = trial >= {1'b0, s_reg[j-1]};
        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= ge ? diff[RW-1:0] : trial[RW-1:0];
                q_reg[j]   <= q_reg[j-1] | (QW'(ge) << (QW - j));
                low_reg[j] <= low_reg[j-1];
                s_reg[j]   <= s_reg[j-1];
                qs_reg[j]  <= qs_reg[j-1];
                cr_reg[j]  <= cr_reg[j-1];
            end
        end
    end

    assign q_over = qs_reg[QW] || q_reg[QW][QW-1];

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
        begin
            if (cr_reg[QW].is_dist)
            begin
                res_reg <= q_over ? cspd_pkg::OUT_MAX : q_reg[QW];
                sat_reg <= cr_reg[QW].sat || q_over;
            end
            else
            begin
                res_reg <= cr_reg[QW].hres;
                sat_reg <= cr_reg[QW].sat;
            end
        end
    end

    assign out_value = res_reg;
    assign out_sat   = sat_reg;

endmodule

>>> sim/cspd_tb_if.sv
`timescale 1ns / 100ps

// the block's channel interfaces live with the RTL; this file holds a small
// tap used by the checker to see both channels through one port list
interface cspd_tap_if;
    logic                              in_fire;
    logic                              func;
    logic signed [31:0]                x_coord;
    logic signed [31:0]                y_coord;
    logic signed [31:0]                z_coord;
    logic                              out_fire;
    logic signed [47:0]                result_value;
    logic                              saturated;

    modport source (output in_fire, func, x_coord, y_coord, z_coord,
                    out_fire, result_value, saturated);
    modport sink (input in_fire, func, x_coord, y_coord, z_coord,
                  out_fire, result_value, saturated);
endinterface

>>> sim/cspd_checker.sv
`timescale 1ns / 100ps

module cspd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cspd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cspd_pkg::CFG_W-1:0]      cfg_data,
    cspd_tap_if.sink                        tap,
    output int                              fail_count,
    output int                              pending
);
    localparam int FB    = 16;
    localparam int WW    = cspd_pkg::WIDE_W;
    localparam int OW    = cspd_pkg::OUT_W;
    localparam int DEPTH = 512;

    typedef struct packed {
        logic [OW-1:0] value;
        logic          sat;
    } answer_t;

    logic [cspd_pkg::CFG_W-1:0] coef_regs [cspd_pkg::N_CFG];
    answer_t                    answer_mem [DEPTH];
    int                         wr_cnt;
    int                         rd_cnt;

    function automatic answer_t surface_answer(logic f, logic signed [31:0] xi,
                                               logic signed [31:0] yi,
                                               logic signed [31:0] zi);
        logic signed [WW-1:0] c [cspd_pkg::N_COEF];
        logic signed [WW-1:0] x, y, hsum, fx, fy, num, g, r, d, a;
        logic [WW-1:0] mag, gm, qu;
        logic [63:0] root, t;
        logic sat;
        answer_t ans;
        sat = 1'b0;
        for (int i = 0; i < cspd_pkg::N_CFG; i++) begin
            c[2*i]   = WW'($signed(coef_regs[i][31:0]));
            c[2*i+1] = WW'($signed(coef_regs[i][63:32]));
        end
        x = WW'(xi);
        y = WW'(yi);
        hsum = (c[0] <<< (3*FB)) + ((c[1]*x) <<< (2*FB)) + ((c[2]*y) <<< (2*FB))
             + ((c[3]*x*x) <<< FB) + ((c[4]*x*y) <<< FB) + ((c[5]*y*y) <<< FB)
             + c[6]*x*x*x + c[7]*x*x*y + c[8]*x*y*y + c[9]*y*y*y;
        if (f == cspd_pkg::FUNC_HEIGHT) begin
            r = hsum >>> (3*FB);
            if (r > $signed({{(WW-OW){1'b0}}, cspd_pkg::OUT_MAX})) begin
                r = {{(WW-OW){1'b0}}, cspd_pkg::OUT_MAX};
                sat = 1'b1;
            end else if (r < -($signed(WW'(1)) <<< 47)) begin
                r = {{(WW-OW){1'b1}}, cspd_pkg::OUT_MIN};
                sat = 1'b1;
            end
            ans.value = r[OW-1:0];
        end else begin
            num = ($signed(WW'(zi)) <<< (3*FB)) - hsum;
            if (num < 0) num = -num;
            fx = (c[1] <<< (2*FB)) + ((2*c[3]*x) <<< FB) + ((c[4]*y) <<< FB)
               + 3*c[6]*x*x + 2*c[7]*x*y + c[8]*y*y;
            fy = (c[2] <<< (2*FB)) + ((c[4]*x) <<< FB) + ((2*c[5]*y) <<< FB)
               + c[7]*x*x + 2*c[8]*x*y + 3*c[9]*y*y;
            g = WW'(1) << (2*FB);
            for (int k = 0; k < 2; k++) begin
                a = ((k == 0) ? fx : fy) >>> (2*FB);
                if (a < 0) a = -a;
                mag = a;
                if (mag > 128'h7FFF_FFFF_FFFF_FFFF) begin
                    mag = 128'h7FFF_FFFF_FFFF_FFFF;
                    sat = 1'b1;
                end
                g = g + mag * mag;
            end
            gm = g;
            root = '0;
            for (int i = 63; i >= 0; i--) begin
                t = root | (64'd1 << i);
                if (!(gm < {64'd0, t} * {64'd0, t})) root = t;
            end
            d = {64'd0, root} << (2*FB);
            qu = $unsigned(num) / $unsigned(d);
            if (qu > {{(WW-OW){1'b0}}, cspd_pkg::OUT_MAX}) begin
                qu = {{(WW-OW){1'b0}}, cspd_pkg::OUT_MAX};
                sat = 1'b1;
            end
            ans.value = qu[OW-1:0];
        end
        ans.sat = sat;
        return ans;
    endfunction

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < cspd_pkg::N_CFG; i++) coef_regs[i] <= '0;
            fail_count <= 0;
            wr_cnt     <= 0;
            rd_cnt     <= 0;
        end else begin
            if (cfg_we && cfg_index < cspd_pkg::CFG_IDX_W'(cspd_pkg::N_CFG))
                coef_regs[cfg_index] <= cfg_data;
            if (tap.in_fire) begin
                answer_mem[wr_cnt % DEPTH] <= surface_answer(tap.func, tap.x_coord,
                                                             tap.y_coord, tap.z_coord);
                wr_cnt <= wr_cnt + 1;
            end
            if (tap.out_fire) begin
                if (rd_cnt == wr_cnt) begin
                    if (fail_count < 10)
                        $display("unexpected result: expected none, got %h sat %b",
                                 tap.result_value, tap.saturated);
                    fail_count <= fail_count + 1;
                end else begin
                    rd_cnt <= rd_cnt + 1;
                    if (answer_mem[rd_cnt % DEPTH].value !== tap.result_value ||
                        answer_mem[rd_cnt % DEPTH].sat !== tap.saturated) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h sat %b, got %h sat %b",
                                     answer_mem[rd_cnt % DEPTH].value,
                                     answer_mem[rd_cnt % DEPTH].sat,
                                     tap.result_value, tap.saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    assign pending = wr_cnt - rd_cnt;
endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [cspd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cspd_pkg::CFG_W-1:0]     cfg_data;
    int                             fail_count;
    int                             pending;
    int                             send_idle;
    int                             recv_idle;

    cspd_in_if  point ();
    cspd_out_if result ();
    cspd_tap_if tap ();

    cubic_surface_point_distance_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point     (point.sink),
        .result    (result.source)
    );

    assign tap.in_fire      = point.valid && point.ready;
    assign tap.func         = point.func;
    assign tap.x_coord      = point.x_coord;
    assign tap.y_coord      = point.y_coord;
    assign tap.z_coord      = point.z_coord;
    assign tap.out_fire     = result.valid && result.ready;
    assign tap.result_value = result.result_value;
    assign tap.saturated    = result.saturated;

    cspd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tap        (tap.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // random coordinate: mostly small magnitudes, sometimes full range
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'h0;
            default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        endcase
    endfunction

    task automatic write_coef(input int idx, input logic [cspd_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= cspd_pkg::CFG_IDX_W'(idx);
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_point(input logic f, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        while ($urandom_range(0, 99) < send_idle) begin
            point.valid <= 1'b0;
            @(negedge clk);
        end
        point.valid   <= 1'b1;
        point.func    <= f;
        point.x_coord <= x;
        point.y_coord <= y;
        point.z_coord <= z;
        @(posedge clk);
        while (!point.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        point.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (130) @(negedge clk);
    endtask

    // receiver stall pattern
    always @(negedge clk)
        result.ready <= ($urandom_range(0, 99) >= recv_idle);

    initial
    begin
        logic [31:0] ext [4];
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        point.valid = 1'b0;
        point.func = cspd_pkg::FUNC_HEIGHT;
        point.x_coord = '0;
        point.y_coord = '0;
        point.z_coord = '0;
        send_idle = 30;
        recv_idle = 81;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero coefficients, then unit-ish and extreme coefficient sets
        for (int s = 0; s < 3; s++) begin
            if (s == 1)
                for (int i = 0; i < cspd_pkg::N_CFG; i++)
                    write_coef(i, {32'h0001_0000, 32'hFFFF_0000});
            if (s == 2)
                for (int i = 0; i < cspd_pkg::N_CFG; i++)
                    write_coef(i, {32'h8000_0000, 32'h7FFF_FFFF});
            for (int k = 0; k < 8; k++)
                send_point(k[0] ? cspd_pkg::FUNC_DIST : cspd_pkg::FUNC_HEIGHT, ext[k % 4],
                           ext[(k / 2) % 4], ext[(k + 1) % 4]);
            drain();
        end

        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 4) begin
                send_idle = 81;
                recv_idle = 30;
            end else if (phase == 8) begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int i = 0; i < cspd_pkg::N_CFG; i++)
                write_coef(i, {pick_coef(), pick_coef()});
            for (int n = 0; n < 100; n++)
                send_point(1'($urandom_range(0, 1)), pick_coord(), pick_coord(), $urandom);
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule

>>> filelist.f
src/cspd_pkg.sv
src/cspd_if.sv
src/cspd_mul.sv
src/cspd_poly.sv
src/cspd_sqrt.sv
src/cspd_div.sv
src/cubic_surface_point_distance_top.sv
sim/cspd_tb_if.sv
sim/cspd_checker.sv
sim/tb.sv
